// ----- design/chks_pkg.sv -----
`timescale 1ns / 1ps
package chks_pkg;
	localparam int BUCKETS_DEF = 251;
	localparam int NODES_DEF = 256;
	localparam int KEY_BITS_DEF = 32;
	localparam int QDEPTH_DEF = 2;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SWEEP,
		BK_HEAD,
		BK_HEAD_W,
		BK_ADD_TAIL,
		BK_ADD_FREE,
		BK_WALK,
		BK_WALK_W,
		BK_UNLINK,
		BK_UNLINK_W,
		BK_DONE
	} bk_state_t;
endpackage

// ----- design/chks_front.sv -----
`timescale 1ns / 1ps
module chks_front #(
	parameter int KEY_BITS = chks_pkg::KEY_BITS_DEF,
	parameter int DEPTH = chks_pkg::QDEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [39:0] s_tdata,
	output logic q_valid,
	input logic q_ready,
	output chks_pkg::cmd_t q_cmd,
	output logic [KEY_BITS-1:0] q_key
);
	import chks_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [1:0] cmd_mem [DEPTH];
	logic [KEY_BITS-1:0] key_mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;
	logic [63:0] kx;

	assign kx = {32'd0, s_tdata[33:2]};
	assign s_tready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign push = s_tvalid && s_tready;
	assign pop = q_valid && q_ready;
	assign q_cmd = cmd_t'(cmd_mem[rp_q]);
	assign q_key = key_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem[wp_q] <= s_tdata[1:0];
			key_mem[wp_q] <= (s_tdata[1:0] == CMD_CLEAR) ? '0 : kx[KEY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue overflow");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop empty");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
endmodule

// ----- design/chks_back.sv -----
`timescale 1ns / 1ps
module chks_back #(
	parameter int BUCKETS = chks_pkg::BUCKETS_DEF,
	parameter int NODES = chks_pkg::NODES_DEF,
	parameter int KEY_BITS = chks_pkg::KEY_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input chks_pkg::cmd_t q_cmd,
	input logic [KEY_BITS-1:0] q_key,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata
);
	import chks_pkg::*;
	localparam int NW = $clog2(NODES + 1);
	localparam int NA = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int BA = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam logic [NW-1:0] NIL = NW'(NODES);
	localparam logic [31:0] BK = 32'(BUCKETS);
	localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));

	// bucket memory holds {head, tail}, cleared by a sweep
	logic [2*NW-1:0] bmem [BUCKETS];
	logic [KEY_BITS-1:0] kmem [NODES];
	logic [NW-1:0] nmem [NODES];

	bk_state_t st_q, st_d;
	cmd_t cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [BA-1:0] b_q;
	logic [NW-1:0] head_q, tail_q, cur_q, prev_q, newn_q;
	logic [NW-1:0] free_q, fresh_q, steps_q;
	logic [KEY_BITS-1:0] rkey_q;
	logic [NW-1:0] rnext_q;
	logic [2*NW-1:0] rb_q;
	logic [1:0] status_q;
	logic found_q, ovalid_q, init_q;
	logic [BA-1:0] sweep_q;

	// key mod buckets by reciprocal multiply and one correction
	logic [1:0] hp_q;
	logic [63:0] prod_q;
	logic [31:0] qb_q, rem_q;
	logic [31:0] k32;

	logic [NW-1:0] walk_n;
	logic walk_end;

	logic b_we, k_we, n_we;
	logic [BA-1:0] b_wa, b_ra;
	logic [2*NW-1:0] b_wd;
	logic [NA-1:0] k_wa, n_wa, n_ra;
	logic [NW-1:0] n_wd;

	assign q_ready = (st_q == BK_IDLE) && !ovalid_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata = {5'd0, found_q, status_q};
	assign k32 = 32'(key_q);
	assign walk_n = (steps_q == '0) ? rb_q[2*NW-1:NW] : cur_q;
	assign walk_end = (walk_n >= NIL) || (steps_q == NIL);

	always_ff @(posedge clk) begin
		if (b_we) bmem[b_wa] <= b_wd;
		rb_q <= bmem[b_ra];
		if (k_we) kmem[k_wa] <= key_q;
		if (n_we) nmem[n_wa] <= n_wd;
		rkey_q <= kmem[n_ra];
		rnext_q <= nmem[n_ra];
	end

	always_comb begin
		st_d = st_q;
		b_we = 1'b0; b_wa = b_q; b_wd = {head_q, tail_q}; b_ra = b_q;
		k_we = 1'b0; k_wa = newn_q[NA-1:0];
		n_we = 1'b0; n_wa = cur_q[NA-1:0]; n_wd = NIL; n_ra = cur_q[NA-1:0];
		case (st_q)
			BK_IDLE: if (q_valid && q_ready) st_d = (q_cmd == CMD_CLEAR) ? BK_SWEEP : BK_HEAD;
			BK_SWEEP: begin
				b_we = 1'b1; b_wa = sweep_q; b_wd = {NIL, NIL};
				if (sweep_q == BA'(BUCKETS-1)) st_d = init_q ? BK_IDLE : BK_DONE;
			end
			BK_HEAD: if (hp_q == 2'd3) st_d = BK_HEAD_W;
			BK_HEAD_W: begin
				if (cmd_q == CMD_ADD) begin
					if (free_q != NIL) begin
						n_ra = free_q[NA-1:0];
						st_d = BK_ADD_FREE;
					end else if (fresh_q != NIL) st_d = BK_ADD_TAIL;
					else st_d = BK_DONE;
				end else st_d = BK_WALK;
			end
			BK_ADD_FREE: st_d = BK_ADD_TAIL;
			BK_ADD_TAIL: begin
				k_we = 1'b1;
				n_we = 1'b1; n_wa = newn_q[NA-1:0]; n_wd = NIL;
				b_we = 1'b1;
				b_wd = {(rb_q[NW-1:0] == NIL) ? newn_q : rb_q[2*NW-1:NW], newn_q};
				st_d = BK_UNLINK_W;
			end
			BK_UNLINK_W: begin
				if (cmd_q == CMD_ADD) begin
					if (tail_q != NIL) begin
						n_we = 1'b1; n_wa = tail_q[NA-1:0]; n_wd = newn_q;
					end
				end else begin
					n_we = 1'b1; n_wa = cur_q[NA-1:0]; n_wd = free_q;
				end
				st_d = BK_DONE;
			end
			BK_WALK: begin
				if (walk_end) st_d = BK_DONE;
				else begin
					n_ra = walk_n[NA-1:0];
					st_d = BK_WALK_W;
				end
			end
			BK_WALK_W: st_d = (rkey_q == key_q) ? BK_UNLINK : BK_WALK;
			BK_UNLINK: begin
				if (cmd_q == CMD_REMOVE) begin
					if (prev_q != NIL) begin
						n_we = 1'b1; n_wa = prev_q[NA-1:0]; n_wd = rnext_q;
					end
					b_we = 1'b1;
					b_wd = {(prev_q == NIL) ? rnext_q : head_q,
						(rnext_q == NIL) ? prev_q : tail_q};
					st_d = BK_UNLINK_W;
				end else st_d = BK_DONE;
			end
			BK_DONE: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_SWEEP;
			init_q <= 1'b1;
			sweep_q <= '0;
			ovalid_q <= 1'b0;
			free_q <= NIL;
			fresh_q <= '0;
			cmd_q <= CMD_CLEAR;
			key_q <= '0;
			b_q <= '0;
			head_q <= NIL;
			tail_q <= NIL;
			cur_q <= NIL;
			prev_q <= NIL;
			newn_q <= NIL;
			steps_q <= '0;
			status_q <= ST_OK;
			found_q <= 1'b0;
			hp_q <= '0;
			prod_q <= '0;
			qb_q <= '0;
			rem_q <= '0;
		end else begin
			st_q <= st_d;
			ovalid_q <= (st_q == BK_DONE) || (ovalid_q && !m_tready);
			case (st_q)
				BK_IDLE: if (q_valid && q_ready) begin
					cmd_q <= q_cmd;
					key_q <= q_key;
					hp_q <= '0;
					sweep_q <= '0;
					status_q <= ST_OK;
					found_q <= 1'b0;
					steps_q <= '0;
					prev_q <= NIL;
				end
				BK_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					free_q <= NIL;
					fresh_q <= '0;
					if (sweep_q == BA'(BUCKETS-1)) init_q <= 1'b0;
				end
				BK_HEAD: begin
					hp_q <= hp_q + 1'b1;
					if (hp_q == 2'd0) prod_q <= 64'(k32) * 64'(RECIP);
					else if (hp_q == 2'd1) qb_q <= prod_q[63:32] * BK;
					else if (hp_q == 2'd2) rem_q <= k32 - qb_q;
					else b_q <= BA'((rem_q >= BK) ? rem_q - BK : rem_q);
				end
				BK_HEAD_W: begin
					if (cmd_q == CMD_ADD) begin
						if (free_q != NIL) newn_q <= free_q;
						else if (fresh_q != NIL) begin
							newn_q <= fresh_q;
							fresh_q <= fresh_q + 1'b1;
						end else status_q <= ST_FULL;
					end
				end
				BK_ADD_FREE: free_q <= rnext_q;
				BK_ADD_TAIL: begin
					head_q <= rb_q[2*NW-1:NW];
					tail_q <= rb_q[NW-1:0];
				end
				BK_WALK: begin
					if (steps_q == '0) begin
						head_q <= rb_q[2*NW-1:NW];
						tail_q <= rb_q[NW-1:0];
					end
					if (walk_end) begin
						if (cmd_q == CMD_REMOVE) status_q <= ST_NOT_FOUND;
					end else begin
						cur_q <= walk_n;
						steps_q <= steps_q + 1'b1;
					end
				end
				BK_WALK_W: if (rkey_q != key_q) begin
					prev_q <= cur_q;
					cur_q <= rnext_q;
				end
				BK_UNLINK: if (cmd_q == CMD_LOOKUP) found_q <= 1'b1;
				BK_UNLINK_W: if (cmd_q == CMD_REMOVE) free_q <= cur_q;
				default: ;
			endcase
		end
	end

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_DONE) |=> ovalid_q) else $error("result lost");
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NIL) else $error("fresh count overrun");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !q_ready) else $error("accept while result pending");
endmodule

// ----- design/chained_hash_key_set_top.sv -----
`timescale 1ns / 1ps
// an add hashes the key, reads the bucket head and tail, then writes the new node and the
// bucket and links the old tail; a recycled node adds a free-list read, and a full pool ends
// without a write; lookup and remove walk the chain one node at a time, a remove that unlinks
// adds the unlink writes; clear sweeps the bucket memory. One command at a time in the back end;
// the next is taken once the result beat is accepted. A two-entry queue in front takes beats while the back end is busy
// reset: asynchronous, then a sweep of the bucket memory before the first command
module chained_hash_key_set_top #(
	parameter int BUCKETS = chks_pkg::BUCKETS_DEF,
	parameter int NODES = chks_pkg::NODES_DEF,
	parameter int KEY_BITS = chks_pkg::KEY_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [39:0] s_tdata, // command, key
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata // status, found
);
	import chks_pkg::*;
	logic q_valid, q_ready;
	cmd_t q_cmd;
	logic [KEY_BITS-1:0] q_key;

	chks_front #(.KEY_BITS(KEY_BITS), .DEPTH(QDEPTH_DEF)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_ready, .q_cmd, .q_key
	);

	chks_back #(.BUCKETS(BUCKETS), .NODES(NODES), .KEY_BITS(KEY_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd, .q_key,
		.m_tvalid, .m_tready, .m_tdata
	);
endmodule
